// ===== src/assert_macros.svh =====
// Assertion macros shared by the byte router modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every rising clock edge outside of reset.
`define RBR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: assertion failed");
// Condition that must never be true outside of reset.
`define RBR_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define RBR_ASSERT(lbl, prop)
`define RBR_NEVER(lbl, cond)
`endif
`endif

// ===== src/rbr_pkg.sv =====
// Types and constants of the UART receive byte router.
package rbr_pkg;

  typedef enum logic [1:0] {
    ActRx     = 2'd0,
    ActPop    = 2'd1,
    ActArmImg = 2'd2,
    ActArmBrd = 2'd3
  } action_e;

  // Image rows hold at most this many bytes; larger sizes are clamped.
  localparam logic [7:0] ImgSizeMax = 8'd128;
  localparam int unsigned AddrW = 16;
  localparam int unsigned RowsW = 5;

  typedef struct packed {
    logic img_active;
    logic brd_active;
    logic mem_write;
    logic board_write;
    logic image_done;
    logic board_done;
  } cap_res_t;

endpackage

// ===== src/uart_rx_byte_router.sv =====
// UART receive byte router: each request carries one action (receive a byte,
// pop the FIFO, arm an image capture, arm a board capture) and yields one
// result. Requests are taken into an input register and processed in a single
// pass into the result register, so one request per cycle is sustained while
// the result side keeps up, and a result is presented as soon as the result
// register loads it. While a result waits at the output, the input register
// still takes one more request, and then the input stalls until the waiting
// result is taken. The FIFO is a single memory with one write and one
// registered read per cycle.
`include "assert_macros.svh"
module uart_rx_byte_router import rbr_pkg::*; #(
  parameter int unsigned FIFO_DEPTH  = 64,
  parameter int unsigned ROW_STRIDE  = 128,
  parameter int unsigned BOARD_BYTES = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      action_i,
  input  logic [7:0]                      rx_byte_i,
  input  logic [15:0]                     image_base_i,
  input  logic [7:0]                      image_size_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            pop_valid_o,
  output logic [7:0]                      pop_data_o,
  output logic                            dropped_o,
  output logic                            mem_write_o,
  output logic [15:0]                     mem_address_o,
  output logic [7:0]                      write_data_o,
  output logic                            board_write_o,
  output logic [((BOARD_BYTES > 1) ? $clog2(BOARD_BYTES) : 1)-1:0] board_index_o,
  output logic                            image_done_o,
  output logic                            board_done_o,
  output logic [$clog2(FIFO_DEPTH+1)-1:0] fifo_count_o
);

  localparam int unsigned BrdW = (BOARD_BYTES > 1) ? $clog2(BOARD_BYTES) : 1;
  localparam int unsigned CntW = $clog2(FIFO_DEPTH + 1);

  // Input register.
  logic             s1_valid_q;
  action_e          act_q;
  logic [7:0]       rx_byte_q;
  logic [AddrW-1:0] base_q;
  logic [7:0]       size_q;

  // Result register.
  logic             out_valid_q;
  logic             pop_valid_q;
  logic             dropped_q;
  logic             mem_write_q;
  logic [AddrW-1:0] mem_address_q;
  logic [7:0]       write_data_q;
  logic             board_write_q;
  logic [BrdW-1:0]  board_index_q;
  logic             image_done_q;
  logic             board_done_q;

  logic             adv;
  logic             rx, push, pop, drop;
  cap_res_t         cap;
  logic [AddrW-1:0] cap_addr;
  logic [BrdW-1:0]  cap_index;
  logic [7:0]       fifo_data;
  logic             fifo_full, fifo_empty;
  logic [CntW-1:0]  fifo_count;

  assign adv        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;

  assign rx   = adv && (act_q == ActRx);
  assign push = rx && !cap.img_active && !cap.brd_active && !fifo_full;
  assign drop = rx && !cap.img_active && !cap.brd_active && fifo_full;
  assign pop  = adv && (act_q == ActPop) && !fifo_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      act_q     <= action_e'(action_i);
      rx_byte_q <= rx_byte_i;
      base_q    <= image_base_i;
      size_q    <= image_size_i;
    end
  end

  rbr_capture #(
    .ROW_STRIDE  (ROW_STRIDE),
    .BOARD_BYTES (BOARD_BYTES)
  ) u_capture (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_i          (rx),
    .arm_img_i     (adv && (act_q == ActArmImg)),
    .arm_brd_i     (adv && (act_q == ActArmBrd)),
    .image_base_i  (base_q),
    .image_size_i  (size_q),
    .res_o         (cap),
    .mem_address_o (cap_addr),
    .board_index_o (cap_index)
  );

  rbr_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (rx_byte_q),
    .pop_i       (pop),
    .pop_data_o  (fifo_data),
    .full_o      (fifo_full),
    .empty_o     (fifo_empty),
    .count_o     (fifo_count)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pop_valid_q   <= pop;
      dropped_q     <= drop;
      mem_write_q   <= cap.mem_write;
      mem_address_q <= cap.mem_write ? cap_addr : '0;
      write_data_q  <= (cap.mem_write || cap.board_write) ? rx_byte_q : '0;
      board_write_q <= cap.board_write;
      board_index_q <= cap.board_write ? cap_index : '0;
      image_done_q  <= cap.image_done;
      board_done_q  <= cap.board_done;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pop_valid_o   = pop_valid_q;
  assign pop_data_o    = pop_valid_q ? fifo_data : '0;
  assign dropped_o     = dropped_q;
  assign mem_write_o   = mem_write_q;
  assign mem_address_o = mem_address_q;
  assign write_data_o  = write_data_q;
  assign board_write_o = board_write_q;
  assign board_index_o = board_index_q;
  assign image_done_o  = image_done_q;
  assign board_done_o  = board_done_q;
  // The count register moves only when a new result is loaded.
  assign fifo_count_o  = fifo_count;

  `RBR_ASSERT(a_one_dest, !out_valid_q || $onehot0({pop_valid_q, dropped_q, mem_write_q, board_write_q}))
  `RBR_NEVER(a_img_done_no_write, out_valid_q && image_done_q && !mem_write_q)
  `RBR_NEVER(a_brd_done_no_write, out_valid_q && board_done_q && !board_write_q)

endmodule

// ===== src/rbr_fifo.sv =====
// Ring FIFO for received bytes with a registered read port.
`include "assert_macros.svh"
module rbr_fifo import rbr_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  input  logic [7:0]                          push_data_i,
  input  logic                                pop_i,
  output logic [7:0]                          pop_data_o,
  output logic                                full_o,
  output logic                                empty_o,
  output logic [$clog2(FIFO_DEPTH+1)-1:0]     count_o
);

  localparam int unsigned PtrW = $clog2(FIFO_DEPTH);
  localparam int unsigned CntW = $clog2(FIFO_DEPTH + 1);

  logic [7:0]      mem_q [FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic [7:0]      rd_data_q;

  assign full_o  = (count_q == CntW'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      count_d  = count_q + 1'b1;
    end else if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      count_d  = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
    if (pop_i) begin
      rd_data_q <= mem_q[rd_ptr_q];
    end
  end

  assign pop_data_o = rd_data_q;
  assign count_o    = count_q;

  `RBR_NEVER(a_push_when_full, push_i && full_o)
  `RBR_NEVER(a_pop_when_empty, pop_i && empty_o)
  `RBR_ASSERT(a_count_bound, count_q <= CntW'(FIFO_DEPTH))

endmodule

// ===== src/rbr_capture.sv =====
// Image and board capture state: address sequencing and arm/done control.
module rbr_capture import rbr_pkg::*; #(
  parameter int unsigned ROW_STRIDE  = 128,
  parameter int unsigned BOARD_BYTES = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rx_i,
  input  logic                  arm_img_i,
  input  logic                  arm_brd_i,
  input  logic [AddrW-1:0]      image_base_i,
  input  logic [7:0]            image_size_i,
  output cap_res_t              res_o,
  output logic [AddrW-1:0]      mem_address_o,
  output logic [((BOARD_BYTES > 1) ? $clog2(BOARD_BYTES) : 1)-1:0] board_index_o
);

  localparam int unsigned BrdW = (BOARD_BYTES > 1) ? $clog2(BOARD_BYTES) : 1;

  logic             img_q, img_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [7:0]       row_left_q, row_left_d;
  logic [RowsW-1:0] rows_q, rows_d;
  logic [7:0]       row_size_q, row_size_d;
  logic             brd_q, brd_d;
  logic [BrdW-1:0]  pos_q, pos_d;
  logic [7:0]       size_clamp;
  logic [7:0]       row_left_dec;
  logic [AddrW-1:0] addr_inc;

  always_comb begin
    if (image_size_i == '0) begin
      size_clamp = 8'd1;
    end else if (image_size_i > ImgSizeMax) begin
      size_clamp = ImgSizeMax;
    end else begin
      size_clamp = image_size_i;
    end
  end

  assign row_left_dec = (row_left_q != '0) ? row_left_q - 1'b1 : '0;
  assign addr_inc     = addr_q + 1'b1;

  always_comb begin
    img_d      = img_q;
    addr_d     = addr_q;
    row_left_d = row_left_q;
    rows_d     = rows_q;
    row_size_d = row_size_q;
    brd_d      = brd_q;
    pos_d      = pos_q;
    res_o      = '0;
    res_o.img_active = img_q;
    res_o.brd_active = brd_q;

    if (rx_i && img_q) begin
      res_o.mem_write = 1'b1;
      addr_d          = addr_inc;
      row_left_d      = row_left_dec;
      if (row_left_dec == '0) begin
        if (rows_q == '0) begin
          img_d            = 1'b0;
          res_o.image_done = 1'b1;
        end else begin
          // Skip to the start of the next row.
          rows_d     = rows_q - 1'b1;
          row_left_d = row_size_q;
          addr_d     = addr_inc + AddrW'(ROW_STRIDE) - {{(AddrW-8){1'b0}}, row_size_q};
        end
      end
    end else if (rx_i && brd_q) begin
      res_o.board_write = 1'b1;
      if (pos_q == BrdW'(BOARD_BYTES - 1)) begin
        pos_d            = '0;
        brd_d            = 1'b0;
        res_o.board_done = 1'b1;
      end else begin
        pos_d = pos_q + 1'b1;
      end
    end

    if (arm_img_i) begin
      img_d      = 1'b1;
      addr_d     = image_base_i;
      row_size_d = size_clamp;
      row_left_d = size_clamp;
      rows_d     = RowsW'(size_clamp >> 3);
    end
    if (arm_brd_i) begin
      brd_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_q      <= 1'b0;
      addr_q     <= '0;
      row_left_q <= '0;
      rows_q     <= '0;
      row_size_q <= '0;
      brd_q      <= 1'b0;
      pos_q      <= '0;
    end else begin
      img_q      <= img_d;
      addr_q     <= addr_d;
      row_left_q <= row_left_d;
      rows_q     <= rows_d;
      row_size_q <= row_size_d;
      brd_q      <= brd_d;
      pos_q      <= pos_d;
    end
  end

  assign mem_address_o = addr_q;
  assign board_index_o = pos_q;

endmodule

// ===== tb/uart_rx_byte_router_checker.sv =====
// Watches the request and result channels of the UART byte router, predicts each result and compares it.
module uart_rx_byte_router_checker import rbr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  action_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [15:0] image_base_i,
  input  logic [7:0]  image_size_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        pop_valid_i,
  input  logic [7:0]  pop_data_i,
  input  logic        dropped_i,
  input  logic        mem_write_i,
  input  logic [15:0] mem_address_i,
  input  logic [7:0]  write_data_i,
  input  logic        board_write_i,
  input  logic [4:0]  board_index_i,
  input  logic        image_done_i,
  input  logic        board_done_i,
  input  logic [6:0]  fifo_count_i,
  output int          mismatches_o,
  output int          routes_waiting_o
);

  localparam logic [6:0]  FifoFull  = 7'd64;
  localparam logic [15:0] RowStride = 16'd128;
  localparam logic [4:0]  BoardLast = 5'd31;

  typedef struct packed {
    logic        pop_valid;
    logic [7:0]  pop_data;
    logic        dropped;
    logic        mem_write;
    logic [15:0] mem_address;
    logic [7:0]  write_data;
    logic        board_write;
    logic [4:0]  board_index;
    logic        image_done;
    logic        board_done;
    logic [6:0]  fifo_count;
  } route_t;

  logic [7:0]  fifo_mem [64];
  logic [5:0]  rd_ptr;
  logic [5:0]  wr_ptr;
  logic [6:0]  held;
  logic        img_on;
  logic [15:0] img_addr;
  logic [7:0]  row_left;
  logic [7:0]  row_len;
  logic [4:0]  rows_left;
  logic        brd_on;
  logic [4:0]  brd_pos;

  route_t pending_routes [$];
  int mismatches = 0;
  int routes_waiting = 0;

  assign mismatches_o     = mismatches;
  assign routes_waiting_o = routes_waiting;

  task automatic route_request(input action_e act, input logic [7:0] b,
                               input logic [15:0] base, input logic [7:0] size_in,
                               output route_t r);
    logic [7:0] size;
    r = '0;
    size = size_in;
    case (act)
      ActRx: begin
        if (img_on) begin
          r.mem_write   = 1'b1;
          r.mem_address = img_addr;
          r.write_data  = b;
          img_addr = img_addr + 16'd1;
          if (row_left != 8'd0) row_left = row_left - 8'd1;
          if (row_left == 8'd0) begin
            if (rows_left == 5'd0) begin
              img_on = 1'b0;
              r.image_done = 1'b1;
            end else begin
              // Jump to the start of the next row.
              rows_left = rows_left - 5'd1;
              row_left  = row_len;
              img_addr  = img_addr + RowStride - {8'd0, row_len};
            end
          end
        end else if (brd_on) begin
          r.board_write = 1'b1;
          r.board_index = brd_pos;
          r.write_data  = b;
          if (brd_pos == BoardLast) begin
            brd_pos = 5'd0;
            brd_on = 1'b0;
            r.board_done = 1'b1;
          end else begin
            brd_pos = brd_pos + 5'd1;
          end
        end else if (held == FifoFull) begin
          r.dropped = 1'b1;
        end else begin
          fifo_mem[wr_ptr] = b;
          wr_ptr = wr_ptr + 6'd1;
          held = held + 7'd1;
        end
      end
      ActPop: begin
        if (held != 7'd0) begin
          r.pop_valid = 1'b1;
          r.pop_data  = fifo_mem[rd_ptr];
          rd_ptr = rd_ptr + 6'd1;
          held = held - 7'd1;
        end
      end
      ActArmImg: begin
        if (size == 8'd0) size = 8'd1;
        else if (size > ImgSizeMax) size = ImgSizeMax;
        img_on    = 1'b1;
        img_addr  = base;
        row_len   = size;
        row_left  = size;
        rows_left = 5'(size / 8);
      end
      default: begin
        brd_on = 1'b1;
      end
    endcase
    r.fifo_count = held;
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    route_t want;
    route_t next_route;
    if (!rst_ni) begin
      foreach (fifo_mem[i]) fifo_mem[i] = 8'd0;
      rd_ptr = '0;
      wr_ptr = '0;
      held = '0;
      img_on = 1'b0;
      img_addr = '0;
      row_left = '0;
      row_len = '0;
      rows_left = '0;
      brd_on = 1'b0;
      brd_pos = '0;
      pending_routes.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_routes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t: result with no request pending", $time);
        end else begin
          want = pending_routes.pop_front();
          check_field("pop_valid", 16'(want.pop_valid), 16'(pop_valid_i));
          check_field("pop_data", 16'(want.pop_data), 16'(pop_data_i));
          check_field("dropped", 16'(want.dropped), 16'(dropped_i));
          check_field("mem_write", 16'(want.mem_write), 16'(mem_write_i));
          check_field("mem_address", want.mem_address, mem_address_i);
          check_field("write_data", 16'(want.write_data), 16'(write_data_i));
          check_field("board_write", 16'(want.board_write), 16'(board_write_i));
          check_field("board_index", 16'(want.board_index), 16'(board_index_i));
          check_field("image_done", 16'(want.image_done), 16'(image_done_i));
          check_field("board_done", 16'(want.board_done), 16'(board_done_i));
          check_field("fifo_count", 16'(want.fifo_count), 16'(fifo_count_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        route_request(action_e'(action_i), rx_byte_i, image_base_i, image_size_i, next_route);
        pending_routes.push_back(next_route);
      end
    end
    routes_waiting = pending_routes.size();
  end

endmodule

// ===== tb/uart_rx_byte_router_test.sv =====
// Top of the UART byte router test: clock, reset, request stimulus, result sink and verdict.
module uart_rx_byte_router_test import rbr_pkg::*; ();

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  action = ActRx;
  logic [7:0]  rx_byte = 8'd0;
  logic [15:0] image_base = 16'd0;
  logic [7:0]  image_size = 8'd1;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        pop_valid;
  logic [7:0]  pop_data;
  logic        dropped;
  logic        mem_write;
  logic [15:0] mem_address;
  logic [7:0]  write_data;
  logic        board_write;
  logic [4:0]  board_index;
  logic        image_done;
  logic        board_done;
  logic [6:0]  fifo_count;
  int          mismatches;
  int          routes_waiting;

  int sent = 0;
  bit sender_calm = 1'b0;

  uart_rx_byte_router DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .action_i      (action),
    .rx_byte_i     (rx_byte),
    .image_base_i  (image_base),
    .image_size_i  (image_size),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .pop_valid_o   (pop_valid),
    .pop_data_o    (pop_data),
    .dropped_o     (dropped),
    .mem_write_o   (mem_write),
    .mem_address_o (mem_address),
    .write_data_o  (write_data),
    .board_write_o (board_write),
    .board_index_o (board_index),
    .image_done_o  (image_done),
    .board_done_o  (board_done),
    .fifo_count_o  (fifo_count)
  );

  uart_rx_byte_router_checker route_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .action_i         (action),
    .rx_byte_i        (rx_byte),
    .image_base_i     (image_base),
    .image_size_i     (image_size),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .pop_valid_i      (pop_valid),
    .pop_data_i       (pop_data),
    .dropped_i        (dropped),
    .mem_write_i      (mem_write),
    .mem_address_i    (mem_address),
    .write_data_i     (write_data),
    .board_write_i    (board_write),
    .board_index_i    (board_index),
    .image_done_i     (image_done),
    .board_done_i     (board_done),
    .fifo_count_i     (fifo_count),
    .mismatches_o     (mismatches),
    .routes_waiting_o (routes_waiting)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("uart_rx_byte_router: mismatch");
    $finish;
  end

  task automatic send_req(input action_e act, input logic [7:0] b,
                          input logic [15:0] base, input logic [7:0] size);
    int gap;
    if (sent % 40 == 0) sender_calm = ($urandom_range(0, 3) == 0);
    gap = sender_calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    rx_byte    <= b;
    image_base <= base;
    image_size <= size;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic send_rx(input logic [7:0] b);
    send_req(ActRx, b, 16'($urandom), 8'($urandom));
  endtask

  task automatic send_pop();
    send_req(ActPop, 8'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic send_arm_image(input logic [15:0] base, input logic [7:0] size);
    send_req(ActArmImg, 8'($urandom), base, size);
  endtask

  task automatic send_arm_board();
    send_req(ActArmBrd, 8'($urandom), 16'($urandom), 8'($urandom));
  endtask

  // Result sink: random stalls, calm stretches, and two long hold-offs that back the block up.
  initial begin : result_sink
    int taken;
    int stall;
    bit calm;
    taken = 0;
    calm = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (taken % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      if (taken == 300 || taken == 800) stall = 300;
      else stall = calm ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin : stimulus
    int r;
    int eff;
    int total;
    logic [7:0] size;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_pop();
    send_rx(8'h00);
    send_rx(8'hFF);
    send_pop();
    send_pop();
    send_pop();
    // Size zero means one: a single one-byte row at the last address, so the next byte
    // goes to the FIFO again.
    send_arm_image(16'hFFFF, 8'd0);
    send_rx(8'hA5);
    send_rx(8'h5A);
    // With both captures armed the image takes the bytes first.
    send_arm_board();
    send_arm_image(16'h1234, 8'd1);
    send_rx(8'h3C);
    send_rx(8'hC3);
    send_rx(8'h81);
    // An oversized row is clamped, then the capture restarts; rearming the board keeps its position.
    send_arm_image(16'h8000, 8'hFF);
    send_rx(8'h7E);
    send_arm_image(16'h00F0, 8'd2);
    send_rx(8'h11);
    send_arm_board();
    send_rx(8'h22);
    send_rx(8'h33);

    while (sent < 1150) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        repeat ($urandom_range(1, 24)) begin
          if ($urandom_range(0, 99) < 55) send_pop();
          else send_rx(8'($urandom));
        end
      end else if (r < 38) begin
        // Overfill the FIFO so that late bytes get dropped.
        repeat ($urandom_range(40, 80)) begin
          if ($urandom_range(0, 9) == 0) send_pop();
          else send_rx(8'($urandom));
        end
      end else if (r < 45) begin
        repeat ($urandom_range(10, 70)) begin
          if ($urandom_range(0, 9) == 0) send_rx(8'($urandom));
          else send_pop();
        end
      end else if (r < 72) begin
        r = $urandom_range(0, 19);
        if (r < 14) size = 8'($urandom_range(1, 15));
        else if (r < 17) size = 8'($urandom_range(16, 40));
        else if (r == 17) size = 8'd0;
        else if (r == 18) size = ImgSizeMax;
        else size = 8'($urandom_range(129, 255));
        eff = (size == 8'd0) ? 1 : (size > ImgSizeMax) ? 128 : int'(size);
        total = (eff / 8 + 1) * eff;
        send_arm_image(16'($urandom), size);
        // Large images and some small ones are cut short by a rearm with a one-byte row.
        if (eff > 40 || $urandom_range(0, 4) == 0) begin
          total = (eff > 40) ? $urandom_range(100, 300) : $urandom_range(1, total);
          repeat (total) send_rx(8'($urandom));
          send_arm_image(16'($urandom), 8'd1);
          total = 2;
        end
        while (total > 0) begin
          r = $urandom_range(0, 99);
          if (r < 12) send_pop();
          else if (r < 14) send_arm_board();
          else begin
            send_rx(8'($urandom));
            total--;
          end
        end
      end else if (r < 87) begin
        send_arm_board();
        repeat ($urandom_range(1, 40)) begin
          r = $urandom_range(0, 99);
          if (r < 10) send_pop();
          else if (r < 13) send_arm_board();
          else send_rx(8'($urandom));
        end
      end else begin
        repeat ($urandom_range(1, 10))
          send_req(action_e'($urandom_range(0, 3)), 8'($urandom), 16'($urandom),
                   8'($urandom_range(0, 24)));
      end
    end
    in_valid <= 1'b0;

    while (routes_waiting != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && routes_waiting == 0) begin
      $display("uart_rx_byte_router: match");
    end else begin
      $display("uart_rx_byte_router: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/rbr_pkg.sv
src/rbr_fifo.sv
src/rbr_capture.sv
src/uart_rx_byte_router.sv
tb/uart_rx_byte_router_checker.sv
tb/uart_rx_byte_router_test.sv
